// ----- sv/worst_k_latency_tracker_unit_macros.svh -----
// Assertion macros for the worst-K latency tracker checker.
// Expects clk and rst_n in the scope of use.
`ifndef WORST_K_LATENCY_TRACKER_UNIT_MACROS_SVH
`define WORST_K_LATENCY_TRACKER_UNIT_MACROS_SVH

// checked only out of reset
`define WKLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WKLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/wklt_pkg.sv -----
// Package for the worst-K latency tracker: widths, command codes,
// stored entry type and control states. No dependencies.
package wklt_pkg;

    localparam int LAT_W  = 34;
    localparam int WORD_W = 64;
    localparam int CMD_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_OFFER = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DUMP  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [LAT_W-1:0]  lat;
        logic [WORD_W-1:0] ctx;
        logic [WORD_W-1:0] stg;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFF_SCAN,
        ST_DMP_SCAN,
        ST_DMP_EMIT,
        ST_DMP_EMPTY
    } state_t;

endpackage

// ----- sv/wklt_ifs.sv -----
// Valid/ready channel interfaces for the sample input and dump output.
// Depends on wklt_pkg.
interface wklt_in_if;
    logic                            valid;
    logic                            ready;
    logic [wklt_pkg::CMD_W-1:0]      command;
    logic [wklt_pkg::LAT_W-1:0]      latency_ns;
    logic [wklt_pkg::WORD_W-1:0]     context_word;
    logic [wklt_pkg::WORD_W-1:0]     stage_times;

    modport source (output valid, command, latency_ns, context_word, stage_times,
                    input ready);
    modport sink   (input valid, command, latency_ns, context_word, stage_times,
                    output ready);
endinterface

interface wklt_out_if;
    logic                            valid;
    logic                            ready;
    logic [wklt_pkg::LAT_W-1:0]      out_latency_ns;
    logic [wklt_pkg::WORD_W-1:0]     out_context;
    logic [wklt_pkg::WORD_W-1:0]     out_stage_times;
    logic                            store_empty;
    logic                            last_item;

    modport source (output valid, out_latency_ns, out_context, out_stage_times,
                    store_empty, last_item, input ready);
    modport sink   (input valid, out_latency_ns, out_context, out_stage_times,
                    store_empty, last_item, output ready);
endinterface

// ----- sv/wklt_store.sv -----
// Entry memory: one write port, one read port, registered read data.
// Depends on wklt_pkg.
module wklt_store #(
    parameter int ADDR_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  wklt_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output wklt_pkg::entry_t    rd_data
);

    wklt_pkg::entry_t mem [0:(2**ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/worst_k_latency_tracker_unit.sv -----
// Worst-K latency tracker: keeps the KEEP_COUNT largest latency samples with their
// context and stage-times words in a two-bank entry memory read one slot per cycle.
// Clear and an offer into a store that is not full are done in the idle state; an offer
// into a full store scans every slot through the read port. A dump of n entries runs n
// selection passes, each a scan and then an emit that waits while the result side
// stalls; it writes the sorted entries into the other bank and then switches banks, and
// a dump of an empty store sends a single empty marker word. The input is ready only
// between commands; the last result may still wait in the output register while the
// next command is taken.
module worst_k_latency_tracker_unit #(
    parameter int KEEP_COUNT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    wklt_in_if.sink        req,
    wklt_out_if.source     rsp
);

    localparam int IDX_W  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int CNT_W  = $clog2(KEEP_COUNT + 1);
    localparam int ADDR_W = IDX_W + 1;

    wklt_pkg::state_t       state_reg, state_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic                   bank_reg, bank_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]       rd_slot_reg, rd_slot_next;
    logic                   best_found_reg, best_found_next;
    logic [IDX_W-1:0]       best_slot_reg, best_slot_next;
    wklt_pkg::entry_t       best_entry_reg, best_entry_next;
    logic [CNT_W-1:0]       rank_reg, rank_next;
    logic [KEEP_COUNT-1:0]  done_reg, done_next;
    wklt_pkg::entry_t       new_entry_reg, new_entry_next;
    logic                   out_valid_reg, out_valid_next;
    wklt_pkg::entry_t       out_entry_reg, out_entry_next;
    logic                   out_empty_reg, out_empty_next;
    logic                   out_last_reg, out_last_next;

    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_wr_addr;
    wklt_pkg::entry_t       mem_wr_data;
    logic                   mem_rd_en;
    logic [ADDR_W-1:0]      mem_rd_addr;
    wklt_pkg::entry_t       mem_rd_data;

    logic                   full;
    logic                   scanning;
    logic                   scan_done;
    logic                   out_free;
    logic                   take;
    logic [CNT_W-1:0]       rank_inc;
    logic                   rank_last;
    wklt_pkg::entry_t       in_entry;

    wklt_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign full      = (fill_reg == CNT_W'(KEEP_COUNT));
    assign scanning  = (state_reg == wklt_pkg::ST_OFF_SCAN) ||
                       (state_reg == wklt_pkg::ST_DMP_SCAN);
    assign scan_done = (scan_idx_reg == fill_reg) && !rd_pend_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rank_inc  = rank_reg + CNT_W'(1);
    assign rank_last = (rank_inc == fill_reg);
    assign in_entry  = '{lat: req.latency_ns, ctx: req.context_word, stg: req.stage_times};

    // offer scan keeps the first minimum; dump scan keeps the first unsent maximum
    always_comb
    begin
        if (state_reg == wklt_pkg::ST_OFF_SCAN)
        begin
            take = !best_found_reg || (mem_rd_data.lat < best_entry_reg.lat);
        end
        else
        begin
            take = !done_reg[rd_slot_reg] &&
                   (!best_found_reg || (mem_rd_data.lat > best_entry_reg.lat));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wklt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.command)
                        wklt_pkg::CMD_OFFER:
                        begin
                            if (full)
                            begin
                                state_next = wklt_pkg::ST_OFF_SCAN;
                            end
                        end
                        wklt_pkg::CMD_DUMP:
                        begin
                            state_next = (fill_reg == '0) ? wklt_pkg::ST_DMP_EMPTY
                                                          : wklt_pkg::ST_DMP_SCAN;
                        end
                        default:
                        begin
                            state_next = wklt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            wklt_pkg::ST_OFF_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = wklt_pkg::ST_IDLE;
                end
            end
            wklt_pkg::ST_DMP_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = wklt_pkg::ST_DMP_EMIT;
                end
            end
            wklt_pkg::ST_DMP_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rank_last ? wklt_pkg::ST_IDLE : wklt_pkg::ST_DMP_SCAN;
                end
            end
            wklt_pkg::ST_DMP_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = wklt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wklt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready       = (state_reg == wklt_pkg::ST_IDLE);
        fill_next       = fill_reg;
        bank_next       = bank_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = 1'b0;
        rd_slot_next    = scan_idx_reg[IDX_W-1:0];
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_entry_next = best_entry_reg;
        rank_next       = rank_reg;
        done_next       = done_reg;
        new_entry_next  = new_entry_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_entry_next  = out_entry_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = {bank_reg, fill_reg[IDX_W-1:0]};
        mem_wr_data     = in_entry;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = {bank_reg, scan_idx_reg[IDX_W-1:0]};

        if (scanning)
        begin
            if (scan_idx_reg != fill_reg)
            begin
                mem_rd_en     = 1'b1;
                rd_pend_next  = 1'b1;
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
            if (rd_pend_reg && take)
            begin
                best_found_next = 1'b1;
                best_slot_next  = rd_slot_reg;
                best_entry_next = mem_rd_data;
            end
        end

        case (state_reg)
            wklt_pkg::ST_IDLE:
            begin
                scan_idx_next   = '0;
                best_found_next = 1'b0;
                if (req.valid)
                begin
                    case (req.command)
                        wklt_pkg::CMD_OFFER:
                        begin
                            new_entry_next = in_entry;
                            if (!full)
                            begin
                                mem_wr_en = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        wklt_pkg::CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        wklt_pkg::CMD_DUMP:
                        begin
                            done_next = '0;
                            rank_next = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                end
            end
            wklt_pkg::ST_OFF_SCAN:
            begin
                if (scan_done && (new_entry_reg.lat > best_entry_reg.lat))
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = {bank_reg, best_slot_reg};
                    mem_wr_data = new_entry_reg;
                end
            end
            wklt_pkg::ST_DMP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_entry_next           = best_entry_reg;
                    out_empty_next           = 1'b0;
                    out_last_next            = rank_last;
                    mem_wr_en                = 1'b1;
                    mem_wr_addr              = {~bank_reg, rank_reg[IDX_W-1:0]};
                    mem_wr_data              = best_entry_reg;
                    done_next[best_slot_reg] = 1'b1;
                    rank_next                = rank_inc;
                    scan_idx_next            = '0;
                    best_found_next          = 1'b0;
                    if (rank_last)
                    begin
                        bank_next = ~bank_reg;
                    end
                end
            end
            wklt_pkg::ST_DMP_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = '0;
                    out_empty_next = 1'b1;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wklt_pkg::ST_IDLE;
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            rank_reg       <= '0;
            done_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bank_reg       <= bank_next;
            scan_idx_reg   <= scan_idx_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            rank_reg       <= rank_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg    <= rd_slot_next;
        best_slot_reg  <= best_slot_next;
        best_entry_reg <= best_entry_next;
        new_entry_reg  <= new_entry_next;
        out_entry_reg  <= out_entry_next;
        out_empty_reg  <= out_empty_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.out_latency_ns  = out_entry_reg.lat;
    assign rsp.out_context     = out_entry_reg.ctx;
    assign rsp.out_stage_times = out_entry_reg.stg;
    assign rsp.store_empty     = out_empty_reg;
    assign rsp.last_item       = out_last_reg;

endmodule

// ----- sv/wklt_checker.sv -----
// Port-level checks for the worst-K latency tracker, bound to the top level.
// Depends on wklt_pkg and worst_k_latency_tracker_unit_macros.svh.
`include "worst_k_latency_tracker_unit_macros.svh"

module wklt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [wklt_pkg::CMD_W-1:0]   in_command,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [wklt_pkg::LAT_W-1:0]   out_latency_ns,
    input logic [wklt_pkg::WORD_W-1:0]  out_context,
    input logic [wklt_pkg::WORD_W-1:0]  out_stage_times,
    input logic                         out_empty,
    input logic                         out_last
);

    // a stalled word holds
    `WKLT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_latency_ns) && $stable(out_context) && $stable(out_stage_times) && $stable(out_last), "stalled output word changed")

    // empty marker comes alone with zero fields
    `WKLT_ASSERT_ALWAYS(a_empty_word, out_valid && out_empty |-> out_last && (out_latency_ns == '0) && (out_context == '0) && (out_stage_times == '0), "bad empty dump word")

    // a dump run in progress blocks new commands
    `WKLT_ASSERT(a_dump_busy, out_valid && !out_last |-> !in_ready, "input ready during a dump run")

    // accepted dump always starts a busy period
    `WKLT_ASSERT(a_dump_start, in_valid && in_ready && (in_command == wklt_pkg::CMD_DUMP) |=> !in_ready, "input ready right after a dump")

endmodule

bind worst_k_latency_tracker_unit wklt_checker u_wklt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .in_command      (req.command),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_latency_ns  (rsp.out_latency_ns),
    .out_context     (rsp.out_context),
    .out_stage_times (rsp.out_stage_times),
    .out_empty       (rsp.store_empty),
    .out_last        (rsp.last_item)
);

// ----- test/tb_worst_k_latency_tracker_unit.sv -----
`timescale 1ns / 100ps
// Self-checking bench for worst_k_latency_tracker_unit: random offer/clear/dump traffic
// with gaps on both channels, checked against a keep-largest-K predictor.
// Depends on wklt_pkg, wklt_in_if / wklt_out_if and the tracker RTL.
module tb_worst_k_latency_tracker_unit;

    localparam int KEEP_COUNT = 8;
    localparam int LAT_W = wklt_pkg::LAT_W;
    localparam int WORD_W = wklt_pkg::WORD_W;
    localparam int CMD_W = wklt_pkg::CMD_W;
    localparam int ITEM_TARGET = 230;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * (KEEP_COUNT * (KEEP_COUNT + 3) + 1);
    localparam int TIMEOUT_NS = 5_000_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [LAT_W-1:0]  lat;
        logic [WORD_W-1:0] ctx;
        logic [WORD_W-1:0] stg;
        logic              empty;
        logic              last;
    } dump_word_t;

    class worst_k_store;
        wklt_pkg::entry_t slots[KEEP_COUNT];
        int unsigned      fill;
        dump_word_t       owed[$];
        int unsigned      errors;
        int unsigned      words;
        int unsigned      offers;
        int unsigned      dumps;
        int unsigned      results;

        function new();
            fill = 0;
            errors = 0;
            words = 0;
            offers = 0;
            dumps = 0;
            results = 0;
        endfunction

        function void offer(wklt_pkg::entry_t e);
            int unsigned low;
            if (fill < KEEP_COUNT)
            begin
                slots[fill] = e;
                fill++;
                return;
            end
            low = 0;
            for (int i = 1; i < KEEP_COUNT; i++)
                if (slots[i].lat < slots[low].lat)
                    low = i;
            if (e.lat > slots[low].lat)
                slots[low] = e;
        endfunction

        // stable descending sort in place, then one word per held entry, or one empty word if none
        function void dump();
            wklt_pkg::entry_t hold;
            int               j;
            dump_word_t       w;
            w = '0;
            if (fill == 0)
            begin
                w.empty = 1'b1;
                w.last = 1'b1;
                owed.push_back(w);
                return;
            end
            for (int i = 1; i < fill; i++)
            begin
                hold = slots[i];
                j = i;
                while (j > 0 && slots[j-1].lat < hold.lat)
                begin
                    slots[j] = slots[j-1];
                    j--;
                end
                slots[j] = hold;
            end
            for (int k = 0; k < fill; k++)
            begin
                w.lat = slots[k].lat;
                w.ctx = slots[k].ctx;
                w.stg = slots[k].stg;
                w.empty = 1'b0;
                w.last = (k == fill - 1);
                owed.push_back(w);
            end
        endfunction

        function void note_word(logic [CMD_W-1:0] cmd, wklt_pkg::entry_t e);
            if (cmd != CMD_UNUSED)
                words++;
            case (cmd)
                wklt_pkg::CMD_OFFER:
                begin
                    offers++;
                    offer(e);
                end
                wklt_pkg::CMD_CLEAR: fill = 0;
                wklt_pkg::CMD_DUMP:
                begin
                    dumps++;
                    dump();
                end
                default: ;
            endcase
        endfunction

        function void check_dump_word(dump_word_t got);
            dump_word_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected dump word lat=%h ctx=%h stg=%h empty=%b last=%b",
                         $time, got.lat, got.ctx, got.stg, got.empty, got.last);
                errors++;
                return;
            end
            want = owed.pop_front();
            results++;
            if (got.lat !== want.lat)
            begin
                $display("%0t: out_latency_ns expected %h got %h", $time, want.lat, got.lat);
                errors++;
            end
            if (got.ctx !== want.ctx)
            begin
                $display("%0t: out_context expected %h got %h", $time, want.ctx, got.ctx);
                errors++;
            end
            if (got.stg !== want.stg)
            begin
                $display("%0t: out_stage_times expected %h got %h", $time, want.stg, got.stg);
                errors++;
            end
            if (got.empty !== want.empty)
            begin
                $display("%0t: store_empty expected %b got %b", $time, want.empty, got.empty);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_item expected %b got %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   hold_cycles;
    worst_k_store store;

    wklt_in_if  req_if ();
    wklt_out_if rsp_if ();

    worst_k_latency_tracker_unit #(
        .KEEP_COUNT(KEEP_COUNT)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d dump words outstanding", store.owed.size());
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // 0: small values with many ties, 1: full range, 2: near the extremes
    function automatic logic [LAT_W-1:0] rand_latency(int mode);
        logic [LAT_W-1:0] v;
        case (mode)
            0: v = LAT_W'($urandom_range(0, 15));
            1: v = {2'($urandom_range(0, 3)), 32'($urandom)};
            default:
            begin
                v = LAT_W'($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    v = ~v;
            end
        endcase
        return v;
    endfunction

    task automatic send_word(logic [CMD_W-1:0] cmd, logic [LAT_W-1:0] lat,
                             logic [WORD_W-1:0] ctx, logic [WORD_W-1:0] stg);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= cmd;
        req_if.latency_ns <= lat;
        req_if.context_word <= ctx;
        req_if.stage_times <= stg;
        do
            @(posedge clk);
        while (!req_if.ready);
        store.note_word(cmd, {lat, ctx, stg});
    endtask

    task automatic send_random(logic [CMD_W-1:0] cmd);
        send_word(cmd, rand_latency(1), rand64(), rand64());
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (store.owed.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin : result_side
        int         stall_left;
        dump_word_t got;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                got = {rsp_if.out_latency_ns, rsp_if.out_context, rsp_if.out_stage_times,
                       rsp_if.store_empty, rsp_if.last_item};
                store.check_dump_word(got);
            end
            if (hold_cycles > 0)
            begin
                stall_left = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left == 0 && !no_gaps)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int n;
        int mode;
        int pick;
        int round;
        store = new();
        no_gaps = 1'b0;
        hold_cycles = 0;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.command <= wklt_pkg::CMD_OFFER;
        req_if.latency_ns <= '0;
        req_if.context_word <= '0;
        req_if.stage_times <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dump, unused code, extremes, ties, replacement rules
        send_word(wklt_pkg::CMD_DUMP, '0, '0, '0);
        send_word(CMD_UNUSED, '1, '1, '1);
        send_word(wklt_pkg::CMD_OFFER, '0, '0, '0);
        send_word(wklt_pkg::CMD_OFFER, '1, '1, '1);
        repeat (3) send_word(wklt_pkg::CMD_OFFER, LAT_W'(5), rand64(), rand64());
        send_word(wklt_pkg::CMD_DUMP, '1, rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(7), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(5), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(100), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(0), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(1), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(5), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(5), rand64(), rand64());
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(6), rand64(), rand64());
        send_word(wklt_pkg::CMD_DUMP, '0, '1, '0);
        send_word(wklt_pkg::CMD_CLEAR, '1, rand64(), rand64());
        send_word(wklt_pkg::CMD_DUMP, '0, '0, '1);
        send_word(wklt_pkg::CMD_OFFER, LAT_W'(3), rand64(), rand64());
        send_word(wklt_pkg::CMD_DUMP, '0, '0, '0);
        drain_results();

        round = 0;
        while (store.words < ITEM_TARGET)
        begin
            no_gaps = (round % 7) == 6;
            if (round == 5)
            begin
                // long result-side hold while words keep coming
                drain_results();
                hold_cycles = HOLD_OFF_CYCLES;
                repeat (KEEP_COUNT)
                    send_word(wklt_pkg::CMD_OFFER, rand_latency(1), rand64(), rand64());
                send_random(wklt_pkg::CMD_DUMP);
                repeat (3) send_word(wklt_pkg::CMD_OFFER, rand_latency(0), rand64(), rand64());
                send_random(wklt_pkg::CMD_DUMP);
                send_random(wklt_pkg::CMD_CLEAR);
                send_random(wklt_pkg::CMD_DUMP);
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_random(wklt_pkg::CMD_CLEAR);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
                mode = $urandom_range(0, 2);
                repeat (n)
                    send_word(wklt_pkg::CMD_OFFER, rand_latency(mode), rand64(), rand64());
                send_random(wklt_pkg::CMD_DUMP);
            end
            else if (pick < 85)
                send_random(wklt_pkg::CMD_DUMP);
            else if (pick < 92)
                send_random(wklt_pkg::CMD_CLEAR);
            else if (pick < 96)
                send_random(CMD_UNUSED);
            else
                repeat ($urandom_range(1, 3)) send_random(wklt_pkg::CMD_OFFER);
            if ($urandom_range(0, 9) == 0)
                drain_results();
            round++;
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d words: %0d offers, %0d dumps, %0d dump words checked",
                 store.words, store.offers, store.dumps, store.results);
        $display("with ties, full-store replacement, clears, empty dumps and a long output hold");
        if (store.errors == 0 && store.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/wklt_pkg.sv
sv/wklt_ifs.sv
sv/wklt_store.sv
sv/worst_k_latency_tracker_unit.sv
sv/wklt_checker.sv
test/tb_worst_k_latency_tracker_unit.sv
